### rtl/sorted_key_pair_matrix_map_unit_macros.svh
// Assertion macros used by the port-level checker of the key-pair matrix map.
`ifndef SORTED_KEY_PAIR_MATRIX_MAP_UNIT_MACROS_SVH
`define SORTED_KEY_PAIR_MATRIX_MAP_UNIT_MACROS_SVH

// Property checked at every rising edge, masked while reset is high.
`define SKP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset cycles included.
`define SKP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/skp_pkg.sv
// Types and constants of the key-pair matrix map.
package skp_pkg;

  localparam int KEY_W     = 64;
  localparam int VAL_W     = 8;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;

  // Flipping the sign bit makes unsigned order equal signed order.
  localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_SRC = 2'd0,
    CMD_LOAD_TGT = 2'd1,
    CMD_PUT      = 2'd2,
    CMD_GET      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_PROBE,
    ST_LOAD_CMP,
    ST_SRCH_PROBE,
    ST_SRCH_CMP,
    ST_STORE_RD,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] source_key;
    logic signed [KEY_W-1:0] target_key;
    logic [VAL_W-1:0]        value_in;
  } req_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [1:0]       status;
  } rsp_item_t;

endpackage

### rtl/skp_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface skp_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/sorted_key_pair_matrix_map_unit.sv
// Top level of the sorted key-pair byte matrix map.
//
//  channel  | dir | payload                                   | transfer when
//  ---------+-----+-------------------------------------------+-------------------
//  req      | in  | cmd, source_key, target_key, value_in     | valid && ready
//  rsp      | out | read_value, status                        | valid && ready
//  cfg      | in  | cfg_index, cfg_data (7 bit counts)        | cfg_wr_en
//
// Operation: a load reads and compares one list entry per key moved aside by
//   the insertion, then hands over; a put or get runs two binary searches,
//   over the row (target) keys and then the column (source) keys, and a get
//   reads the store. Probes share one key comparator and one read port per list.
// Reset: synchronous; afterwards the value store is cleared one byte a cycle,
//   all MAX_SOURCE_KEYS * MAX_TARGET_KEYS bytes, with req.ready low throughout.
// Stalls: a finished result sits in the rsp register; the next request is
//   taken meanwhile, and only a second result waits for the slot to drain.
module sorted_key_pair_matrix_map_unit import skp_pkg::*; #(
  parameter int MAX_SOURCE_KEYS = 64,
  parameter int MAX_TARGET_KEYS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  skp_stream_if.sink           req,
  skp_stream_if.source         rsp,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  logic [CNT_W-1:0] source_count, target_count;
  logic             start, done, res_free;
  rsp_item_t        res;
  logic             seq_ready;

  // configuration registers; the user writes them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= '0;
      target_count <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SOURCE_COUNT: source_count <= cfg_data;
        REG_TARGET_COUNT: target_count <= cfg_data;
      endcase
    end
  end

  assign req.ready = seq_ready;
  assign start     = req.valid && seq_ready;

  // result slot: free when empty or being drained this cycle
  assign res_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (done && res_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_free) begin
      rsp.data <= res;
    end
  end

  skp_seq #(
    .MAX_SOURCE_KEYS (MAX_SOURCE_KEYS),
    .MAX_TARGET_KEYS (MAX_TARGET_KEYS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_data     (req.data),
    .req_ready    (seq_ready),
    .source_count (source_count),
    .target_count (target_count),
    .done         (done),
    .res          (res),
    .res_free     (res_free)
  );

endmodule

### rtl/skp_key_list.sv
// Sorted key list storage: one write port, one registered read port.
module skp_key_list import skp_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [KEY_W-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [KEY_W-1:0]                      rdata
);

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/skp_value_store.sv
// Byte matrix storage: single address, write or registered read.
module skp_value_store import skp_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [VAL_W-1:0]                      wdata,
  output logic [VAL_W-1:0]                      rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/skp_seq.sv
// Sequencer with the shared key comparator: insertion, binary search, store clear and access.
module skp_seq import skp_pkg::*; #(
  parameter int MAX_SOURCE_KEYS = 64,
  parameter int MAX_TARGET_KEYS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_item_t        req_data,
  output logic             req_ready,
  input  logic [CNT_W-1:0] source_count,
  input  logic [CNT_W-1:0] target_count,
  output logic             done,
  output rsp_item_t        res,
  input  logic             res_free
);

  localparam int KMAX  = (MAX_SOURCE_KEYS > MAX_TARGET_KEYS) ? MAX_SOURCE_KEYS
                                                              : MAX_TARGET_KEYS;
  localparam int CW    = $clog2(KMAX + 1);
  localparam int LW    = (CW > CNT_W) ? CW : CNT_W;
  localparam int SAW   = (MAX_SOURCE_KEYS > 1) ? $clog2(MAX_SOURCE_KEYS) : 1;
  localparam int TAW   = (MAX_TARGET_KEYS > 1) ? $clog2(MAX_TARGET_KEYS) : 1;
  localparam int DEPTH = MAX_SOURCE_KEYS * MAX_TARGET_KEYS;
  localparam int VAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  seq_state_t state, state_next;

  cmd_t             cmd_q;
  logic [KEY_W-1:0] skey_q, tkey_q;
  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] rdval_q;
  status_t          status_q;
  logic             sel_tgt;
  logic [CW-1:0]    pos, lo, hi, mid;
  logic             eqf;
  logic [TAW-1:0]   row;
  logic [CW-1:0]    s_loaded, t_loaded;
  logic [VAW-1:0]   clr;

  // list and store ports
  logic             s_we, t_we, v_we;
  logic [CW-1:0]    l_waddr, l_raddr;
  logic [KEY_W-1:0] l_wdata, s_rdata, t_rdata;
  logic [VAW-1:0]   v_addr;
  logic [VAL_W-1:0] v_wdata, v_rdata;

  // active lengths and fill limits
  logic [LW-1:0] s_cap, t_cap, s_len, t_len;
  logic          s_full, t_full;
  logic [CW-1:0] n_s, n_t, n_cur;

  logic [KEY_W-1:0] key_cur, rd_cur;
  logic             cmp_gt, cmp_lt, cmp_eq;
  logic [CW-1:0]    mid_c;
  logic             srch_more, found;
  logic [VAW-1:0]   store_addr;
  logic             req_load, req_full;

  always_comb begin
    s_cap  = (LW'(source_count) > LW'(MAX_SOURCE_KEYS)) ? LW'(MAX_SOURCE_KEYS)
                                                        : LW'(source_count);
    t_cap  = (LW'(target_count) > LW'(MAX_TARGET_KEYS)) ? LW'(MAX_TARGET_KEYS)
                                                        : LW'(target_count);
    s_len  = (LW'(s_loaded) < s_cap) ? LW'(s_loaded) : s_cap;
    t_len  = (LW'(t_loaded) < t_cap) ? LW'(t_loaded) : t_cap;
    s_full = LW'(s_loaded) >= s_cap;
    t_full = LW'(t_loaded) >= t_cap;
    n_s    = CW'(s_len);
    n_t    = CW'(t_len);
    n_cur  = sel_tgt ? n_t : n_s;
  end

  // the one shared comparator, on sign-flipped keys
  assign key_cur = sel_tgt ? tkey_q : skey_q;
  assign rd_cur  = sel_tgt ? t_rdata : s_rdata;
  assign cmp_gt  = rd_cur > key_cur;
  assign cmp_lt  = rd_cur < key_cur;
  assign cmp_eq  = rd_cur == key_cur;

  assign mid_c      = lo + ((hi - lo) >> 1);
  assign srch_more  = lo < hi;
  assign found      = (hi < n_cur) && eqf;
  assign store_addr = VAW'(row) * VAW'(MAX_SOURCE_KEYS) + VAW'(hi);

  assign req_load = (cmd_t'(req_data.cmd) == CMD_LOAD_SRC) ||
                    (cmd_t'(req_data.cmd) == CMD_LOAD_TGT);
  assign req_full = (cmd_t'(req_data.cmd) == CMD_LOAD_TGT) ? t_full : s_full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == VAW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (!req_load)    state_next = ST_SRCH_PROBE;
          else if (req_full) state_next = ST_DONE;
          else              state_next = ST_LOAD_PROBE;
        end
      end
      ST_LOAD_PROBE: state_next = (pos == '0) ? ST_DONE : ST_LOAD_CMP;
      ST_LOAD_CMP:   state_next = cmp_gt ? ST_LOAD_PROBE : ST_DONE;
      ST_SRCH_PROBE: begin
        priority if (srch_more)   state_next = ST_SRCH_CMP;
        else if (!found)         state_next = ST_DONE;
        else if (sel_tgt)        state_next = ST_SRCH_PROBE;
        else if (cmd_q == CMD_GET) state_next = ST_STORE_RD;
        else                     state_next = ST_DONE;
      end
      ST_SRCH_CMP: state_next = ST_SRCH_PROBE;
      ST_STORE_RD: state_next = ST_DONE;
      ST_DONE: begin
        if (res_free) state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and memory controls
  always_comb begin
    req_ready = 1'b0;
    done      = 1'b0;
    s_we      = 1'b0;
    t_we      = 1'b0;
    l_waddr   = pos;
    l_wdata   = key_cur;
    l_raddr   = pos - 1'b1;
    v_we      = 1'b0;
    v_addr    = store_addr;
    v_wdata   = val_q;
    unique case (state)
      ST_CLEAR: begin
        v_we    = 1'b1;
        v_addr  = clr;
        v_wdata = '0;
      end
      ST_IDLE: req_ready = 1'b1;
      ST_LOAD_PROBE: begin
        if (pos == '0) begin
          s_we = !sel_tgt;
          t_we = sel_tgt;
        end
      end
      ST_LOAD_CMP: begin
        s_we    = !sel_tgt;
        t_we    = sel_tgt;
        l_wdata = cmp_gt ? rd_cur : key_cur;
      end
      ST_SRCH_PROBE: begin
        l_raddr = mid_c;
        if (!srch_more && found && !sel_tgt) begin
          v_we = (cmd_q == CMD_PUT);
        end
      end
      ST_SRCH_CMP: ;
      ST_STORE_RD: ;
      ST_DONE: done = 1'b1;
    endcase
  end

  assign res.read_value = rdval_q;
  assign res.status     = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      s_loaded <= '0;
      t_loaded <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: clr <= clr + 1'b1;
        ST_IDLE: begin
          if (start) begin
            cmd_q    <= cmd_t'(req_data.cmd);
            skey_q   <= req_data.source_key ^ SIGN_FLIP;
            tkey_q   <= req_data.target_key ^ SIGN_FLIP;
            val_q    <= req_data.value_in;
            rdval_q  <= '0;
            status_q <= (req_load && req_full) ? STAT_FULL : STAT_OK;
            sel_tgt  <= cmd_t'(req_data.cmd) != CMD_LOAD_SRC;
            pos      <= (cmd_t'(req_data.cmd) == CMD_LOAD_TGT) ? t_loaded : s_loaded;
            lo       <= '0;
            hi       <= n_t;
            eqf      <= 1'b0;
          end
        end
        ST_LOAD_PROBE: begin
          if (pos == '0) begin
            if (sel_tgt) t_loaded <= t_loaded + 1'b1;
            else         s_loaded <= s_loaded + 1'b1;
          end
        end
        ST_LOAD_CMP: begin
          if (cmp_gt) begin
            pos <= pos - 1'b1;
          end else if (sel_tgt) begin
            t_loaded <= t_loaded + 1'b1;
          end else begin
            s_loaded <= s_loaded + 1'b1;
          end
        end
        ST_SRCH_PROBE: begin
          priority if (srch_more) begin
            mid <= mid_c;
          end else if (!found) begin
            status_q <= STAT_NOT_FOUND;
          end else if (sel_tgt) begin
            // row settled, go on to the column search
            row     <= hi[TAW-1:0];
            sel_tgt <= 1'b0;
            lo      <= '0;
            hi      <= n_s;
            eqf     <= 1'b0;
          end else begin
            row <= row;
          end
        end
        ST_SRCH_CMP: begin
          if (cmp_lt) begin
            lo <= mid + 1'b1;
          end else begin
            hi  <= mid;
            eqf <= cmp_eq;
          end
        end
        ST_STORE_RD: rdval_q <= v_rdata;
        ST_DONE: ;
      endcase
    end
  end

  skp_key_list #(.DEPTH(MAX_SOURCE_KEYS)) u_src_list (
    .clk   (clk),
    .we    (s_we),
    .waddr (l_waddr[SAW-1:0]),
    .wdata (l_wdata),
    .raddr (l_raddr[SAW-1:0]),
    .rdata (s_rdata)
  );

  skp_key_list #(.DEPTH(MAX_TARGET_KEYS)) u_tgt_list (
    .clk   (clk),
    .we    (t_we),
    .waddr (l_waddr[TAW-1:0]),
    .wdata (l_wdata),
    .raddr (l_raddr[TAW-1:0]),
    .rdata (t_rdata)
  );

  skp_value_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (v_we),
    .addr  (v_addr),
    .wdata (v_wdata),
    .rdata (v_rdata)
  );

endmodule

### rtl/skp_checker.sv
// Port-level checks of the key-pair matrix map, bound to the top level.
`include "sorted_key_pair_matrix_map_unit_macros.svh"

module skp_checker import skp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp_data
);

  `SKP_ASSERT_ALWAYS(a_rst_clears_rsp, clk, rst |=> !rsp_valid, "result valid after reset")
  `SKP_ASSERT_ALWAYS(a_rst_busy, clk, rst |=> !req_ready, "ready during store clear")
  `SKP_ASSERT(a_busy_after_accept, clk, rst, req_valid && req_ready |=> !req_ready, "accepted twice in a row")
  `SKP_ASSERT(a_fail_reads_zero, clk, rst, rsp_valid && (rsp_data.status != STAT_OK) |-> rsp_data.read_value == '0, "failed command returned data")
  `SKP_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind sorted_key_pair_matrix_map_unit skp_checker u_skp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

### tb/sorted_key_pair_matrix_map_unit_checker.sv
// Checker for the key-pair matrix map: predicts each response and compares it.
`timescale 1ns / 1ps
module sorted_key_pair_matrix_map_unit_checker import skp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  req_item_t            req_data,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  rsp_item_t            rsp_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  localparam int KEY_SLOTS = 64;

  // Lists are indexed by the index of their count register.
  logic signed [KEY_W-1:0] key_list [2][KEY_SLOTS];
  int                      keys_loaded [2];
  logic [CNT_W-1:0]        key_count [2];
  logic [VAL_W-1:0]        byte_cells [KEY_SLOTS*KEY_SLOTS];
  rsp_item_t               expected_outcomes [$];

  function automatic int list_cap(logic [CFG_IDX_W-1:0] l);
    return (key_count[l] > KEY_SLOTS) ? KEY_SLOTS : int'(key_count[l]);
  endfunction

  // Lowest sorted position of key among the active keys, -1 if absent.
  function automatic int key_position(logic [CFG_IDX_W-1:0] l,
                                      logic signed [KEY_W-1:0] key);
    int n;
    int lo;
    int hi;
    int mid;
    n  = (keys_loaded[l] < list_cap(l)) ? keys_loaded[l] : list_cap(l);
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key_list[l][mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (lo < n && key_list[l][lo] == key) return lo;
    return -1;
  endfunction

  function automatic status_t insert_key(logic [CFG_IDX_W-1:0] l,
                                         logic signed [KEY_W-1:0] key);
    int pos;
    if (keys_loaded[l] >= list_cap(l)) return STAT_FULL;
    pos = keys_loaded[l];
    while (pos > 0 && key_list[l][pos-1] > key) begin
      key_list[l][pos] = key_list[l][pos-1];
      pos--;
    end
    key_list[l][pos] = key;
    keys_loaded[l]++;
    return STAT_OK;
  endfunction

  function automatic rsp_item_t map_outcome(req_item_t it);
    rsp_item_t r;
    int        row;
    int        col;
    r = '0;
    case (it.cmd)
      CMD_LOAD_SRC: r.status = insert_key(REG_SOURCE_COUNT, it.source_key);
      CMD_LOAD_TGT: r.status = insert_key(REG_TARGET_COUNT, it.target_key);
      default: begin
        row = key_position(REG_TARGET_COUNT, it.target_key);
        col = key_position(REG_SOURCE_COUNT, it.source_key);
        if (row < 0 || col < 0) begin
          r.status = STAT_NOT_FOUND;
        end else if (it.cmd == CMD_PUT) begin
          byte_cells[row*KEY_SLOTS + col] = it.value_in;
        end else begin
          r.read_value = byte_cells[row*KEY_SLOTS + col];
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      foreach (byte_cells[i]) byte_cells[i] = '0;
      foreach (key_list[l, i]) key_list[l][i] = '0;
      keys_loaded = '{0, 0};
      key_count   = '{default: '0};
      expected_outcomes.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) key_count[cfg_index] = cfg_data;
      if (req_valid && req_ready) expected_outcomes.push_back(map_outcome(req_data));
      if (rsp_valid && rsp_ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("unexpected response: read_value %0d status %0d",
                 rsp_data.read_value, rsp_data.status);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d",
                   want.read_value, rsp_data.read_value);
            mismatches++;
          end
          if (rsp_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_outcomes.size();
  end

endmodule

### tb/sorted_key_pair_matrix_map_unit_tb.sv
// Testbench top for the key-pair matrix map: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module sorted_key_pair_matrix_map_unit_tb;
  import skp_pkg::*;

  localparam int CYCLE_LIMIT   = 1_200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int KEY_SLOTS     = 64;
  localparam logic signed [KEY_W-1:0] KEY_MIN = SIGN_FLIP;
  localparam logic signed [KEY_W-1:0] KEY_MAX = ~SIGN_FLIP;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;

  // Idling on both sides; cleared for the long unbroken stretch.
  bit gaps_on = 1'b1;

  // Keys known to have gone into each list, so lookups can be aimed at hits.
  // The pools stop growing once a list reaches its configured size.
  int                      src_cap;
  int                      tgt_cap;
  logic signed [KEY_W-1:0] src_pool [$];
  logic signed [KEY_W-1:0] tgt_pool [$];

  skp_stream_if #(.payload_t(req_item_t)) req_ch ();
  skp_stream_if #(.payload_t(rsp_item_t)) rsp_ch ();

  sorted_key_pair_matrix_map_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sorted_key_pair_matrix_map_unit_checker map_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_data    (req_ch.data),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_data    (rsp_ch.data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (clear pass, worst-case
  // insertions, every stall).
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sorted_key_pair_matrix_map_unit_tb failed");
    $finish;
  end

  // Response side: random back-pressure, one drive per edge.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= gaps_on ? ($urandom_range(99) >= 27) : 1'b1;
    end
  end

  // Small keys make duplicates likely; the extremes and full-width random
  // values make every key bit toggle.
  function automatic logic signed [KEY_W-1:0] random_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(3))
      0: begin
        k = $urandom_range(16);
        k = k - 8;
      end
      1: begin
        case ($urandom_range(3))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = -1;
          default: k = 0;
        endcase
      end
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  // Mostly keys already loaded, with a bias to the first few so that gets
  // land on cells written earlier; the rest are probably absent.
  function automatic logic signed [KEY_W-1:0] lookup_key(bit from_targets);
    int n;
    int idx;
    n = from_targets ? tgt_pool.size() : src_pool.size();
    if (n == 0 || $urandom_range(99) < 15) return random_key();
    idx = $urandom_range(1) ? $urandom_range(n < 4 ? n - 1 : 3) : $urandom_range(n - 1);
    return from_targets ? tgt_pool[idx] : src_pool[idx];
  endfunction

  // One request transfer. valid stays high afterwards so back-to-back
  // requests need no extra drive; the next call replaces the item or lowers valid for a gap, and a drain lowers it.
  task automatic send_item(cmd_t cmd, logic signed [KEY_W-1:0] skey,
                           logic signed [KEY_W-1:0] tkey, logic [VAL_W-1:0] val);
    req_item_t it;
    it.cmd        = cmd;
    it.source_key = skey;
    it.target_key = tkey;
    it.value_in   = val;
    if (gaps_on) begin
      while ($urandom_range(99) < 27) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    do @(posedge clk); while (!req_ch.ready);
    if (cmd == CMD_LOAD_SRC && src_pool.size() < src_cap) src_pool.push_back(skey);
    if (cmd == CMD_LOAD_TGT && tgt_pool.size() < tgt_cap) tgt_pool.push_back(tkey);
  endtask

  // Stop requesting and wait until every response has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Count writes only ever happen with the block idle.
  task automatic set_counts(int src_count, int tgt_count);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SOURCE_COUNT;
    cfg_data  <= CNT_W'(src_count);
    @(posedge clk);
    cfg_index <= REG_TARGET_COUNT;
    cfg_data  <= CNT_W'(tgt_count);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    src_cap = (src_count > KEY_SLOTS) ? KEY_SLOTS : src_count;
    tgt_cap = (tgt_count > KEY_SLOTS) ? KEY_SLOTS : tgt_count;
  endtask

  task automatic run_mix(int n, int load_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < load_pct / 2)
        send_item(CMD_LOAD_SRC, random_key(), random_key(), VAL_W'($urandom));
      else if (r < load_pct)
        send_item(CMD_LOAD_TGT, random_key(), random_key(), VAL_W'($urandom));
      else
        send_item($urandom_range(1) ? CMD_GET : CMD_PUT, lookup_key(1'b0),
                  lookup_key(1'b1), VAL_W'($urandom));
    end
  endtask

  initial begin
    src_cap = 0;
    tgt_cap = 0;
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_SOURCE_COUNT;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: both counts are zero out of reset, so nothing is active
    // and any load is refused as full.
    send_item(CMD_GET, 0, 0, 8'h00);
    send_item(CMD_LOAD_SRC, 5, 0, 8'h00);

    // Three columns, two rows. A lookup while the row list is still empty,
    // a duplicate column key, then loads past the count.
    set_counts(3, 2);
    send_item(CMD_LOAD_SRC, KEY_MIN, 0, 8'h00);
    send_item(CMD_PUT, KEY_MIN, KEY_MAX, 8'h11);
    send_item(CMD_LOAD_TGT, 0, KEY_MAX, 8'hFF);
    send_item(CMD_LOAD_SRC, KEY_MAX, KEY_MIN, 8'h00);
    send_item(CMD_LOAD_SRC, KEY_MAX, 0, 8'h00);
    send_item(CMD_LOAD_SRC, 0, 0, 8'h00);
    send_item(CMD_LOAD_TGT, KEY_MAX, KEY_MIN, 8'h00);
    send_item(CMD_LOAD_TGT, 0, 7, 8'h00);

    // Corner cells and byte extremes; a never-written cell reads zero.
    send_item(CMD_PUT, KEY_MAX, KEY_MIN, 8'hFF);
    send_item(CMD_PUT, KEY_MIN, KEY_MAX, 8'h00);
    send_item(CMD_GET, KEY_MAX, KEY_MIN, 8'h00);
    send_item(CMD_GET, KEY_MIN, KEY_MAX, 8'hFF);
    send_item(CMD_GET, KEY_MAX, KEY_MAX, 8'h00);
    send_item(CMD_GET, -1, KEY_MIN, 8'h00);
    send_item(CMD_PUT, KEY_MIN, KEY_MIN, 8'h5A);

    // Shrink the columns below what is loaded (only the lowest key stays
    // active) and give the rows a count above the list size.
    set_counts(1, 127);
    send_item(CMD_GET, KEY_MAX, KEY_MIN, 8'h00);
    send_item(CMD_GET, KEY_MIN, KEY_MIN, 8'h00);
    send_item(CMD_LOAD_SRC, 3, 0, 8'h00);
    send_item(CMD_LOAD_TGT, 0, 0, 8'h00);

    // Random phases; loaded keys are never cleared, so the lists fill up
    // over the run while the counts move around them.
    set_counts(16, 8);
    run_mix(300, 30);

    // Full lists with an out-of-range count, no idling on either side.
    set_counts(127, 64);
    gaps_on = 1'b0;
    run_mix(500, 25);
    set_counts(5, 40);
    gaps_on = 1'b1;
    run_mix(300, 20);

    // No rows active: every lookup misses and every row load is full.
    set_counts(64, 0);
    run_mix(100, 20);
    set_counts(64, 64);
    run_mix(650, 20);

    drain();
    if (mismatches == 0) begin
      $display("sorted_key_pair_matrix_map_unit_tb passed");
    end else begin
      $display("sorted_key_pair_matrix_map_unit_tb failed");
    end
    $finish;
  end

endmodule
